// ----- hdl/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths, register codes, reset values and types of the pinhole
// point projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

	localparam int COORD_W = 24;
	localparam int ROT_W   = 16;
	localparam int TR_W    = 21;
	localparam int PROD_W  = ROT_W + COORD_W;
	localparam int ACC_W   = 42;
	localparam int NUM_W   = 2 * COORD_W + 1;
	localparam int MAG_W   = 2 * COORD_W;
	localparam int DEN_W   = COORD_W;
	localparam int Q_W     = 25;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 63;

	localparam logic [IDX_W-1:0] REG_ROT0  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT1  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT2  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [IDX_W-1:0] REG_FOCAL = 3'd4;
	localparam logic [IDX_W-1:0] REG_PRINC = 3'd5;
	localparam logic [IDX_W-1:0] REG_INTEG = 3'd6;

	localparam logic [47:0] ROT0_RST  = 48'd16384;
	localparam logic [47:0] ROT1_RST  = 48'd1073741824;
	localparam logic [47:0] ROT2_RST  = 48'd70368744177664;
	localparam logic [62:0] TRANS_RST = 63'd0;
	localparam logic [47:0] FOCAL_RST = 48'd4294967552;
	localparam logic [47:0] PRINC_RST = 48'd0;

	localparam logic signed [COORD_W-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] Q_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [COORD_W-1:0] val;
		logic                      sat;
	} rc_t;

	typedef struct packed {
		logic [1:0] neg;
		logic [1:0] ovf;
		logic       zd;
		logic       sat;
	} side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      zd;
		logic                      sat;
	} pix_t;

	// q.22 to q.8, nearest with ties away from zero, then clamp
	function automatic rc_t round_clamp(input logic signed [ACC_W-1:0] a);
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] r;
		rc_t res;
		m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
		r = (m + ACC_W'(8192)) >> 14;
		res.sat = 1'b0;
		if (!a[ACC_W-1]) begin
			if (r > ACC_W'(8388607)) begin
				res.val = Q_MAX;
				res.sat = 1'b1;
			end else begin
				res.val = COORD_W'(r);
			end
		end else begin
			if (r > ACC_W'(8388608)) begin
				res.val = Q_MIN;
				res.sat = 1'b1;
			end else begin
				res.val = COORD_W'(-r);
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ppp_ifs.sv -----
// ----------------------------------------------------------------------------
// ppp channel interfaces
// Valid/ready channels for points, pixels and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppp_point_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic signed [23:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_pixel_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pixel_x;
	logic signed [23:0] pixel_y;
	logic               zero_depth;
	logic               saturated;
	modport source (output valid, pixel_x, pixel_y, zero_depth, saturated, input ready);
	modport sink (input valid, pixel_x, pixel_y, zero_depth, saturated, output ready);
endinterface

interface ppp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [62:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ppp_cam.sv -----
// ----------------------------------------------------------------------------
// ppp_cam
// Rigid transform R*P + t in three stages: products, sums, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_cam (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             in_valid,
	input  wire logic signed [ppp_pkg::COORD_W-1:0] px,
	input  wire logic signed [ppp_pkg::COORD_W-1:0] py,
	input  wire logic signed [ppp_pkg::COORD_W-1:0] pz,
	input  wire logic [47:0]                      rot0,
	input  wire logic [47:0]                      rot1,
	input  wire logic [47:0]                      rot2,
	input  wire logic [62:0]                      trans,
	output logic                                  valid_s3,
	output logic signed [ppp_pkg::COORD_W-1:0]    cam_s3 [3],
	output logic                                  sat_s3
);
	import ppp_pkg::*;

	logic [47:0]               rows [3];
	logic signed [COORD_W-1:0] p [3];
	logic signed [PROD_W-1:0]  prod_s1 [3][3];
	logic signed [ACC_W-1:0]   acc_s2 [3];
	logic                      valid_s1;
	logic                      valid_s2;
	rc_t                       rc [3];
	logic                      sat_any;

	assign rows[0] = rot0;
	assign rows[1] = rot1;
	assign rows[2] = rot2;
	assign p[0] = px;
	assign p[1] = py;
	assign p[2] = pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		sat_any = 1'b0;
		for (int r = 0; r < 3; r++) begin
			rc[r] = round_clamp(acc_s2[r]);
			sat_any = sat_any | rc[r].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= $signed(rows[r][16*k +: 16]) * p[k];
				end
				acc_s2[r] <= $signed({{7{trans[21*r+20]}}, trans[21*r +: 21], 14'b0})
					+ ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1]) + ACC_W'(prod_s1[r][2]);
				cam_s3[r] <= rc[r].val;
			end
			sat_s3 <= sat_any;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ppp_div.sv -----
// ----------------------------------------------------------------------------
// ppp_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire ppp_pkg::side_t             in_side,
	input  wire logic [ppp_pkg::MAG_W-1:0]  in_num [2],
	input  wire logic [ppp_pkg::DEN_W-1:0]  in_den,
	output logic                            out_valid,
	output ppp_pkg::side_t                  out_side,
	output logic [ppp_pkg::Q_W-1:0]         out_q [2]
);
	import ppp_pkg::*;

	logic             vld_s  [0:Q_W];
	side_t            side_s [0:Q_W];
	logic [DEN_W-1:0] den_s  [0:Q_W];
	logic [MAG_W-1:0] rem_s  [0:Q_W][2];
	logic [Q_W-1:0]   quo_s  [0:Q_W][2];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;
	assign den_s[0]  = in_den;
	assign rem_s[0][0] = in_num[0];
	assign rem_s[0][1] = in_num[1];
	assign quo_s[0][0] = '0;
	assign quo_s[0][1] = '0;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int B = Q_W - 1 - k;
		logic [MAG_W-1:0] dsh;
		logic [MAG_W-1:0] nrem [2];
		logic [Q_W-1:0]   nquo [2];

		always_comb begin
			dsh = MAG_W'(den_s[k]) << B;
			for (int l = 0; l < 2; l++) begin
				if (rem_s[k][l] >= dsh) begin
					nrem[l] = rem_s[k][l] - dsh;
					nquo[l] = {quo_s[k][l][Q_W-2:0], 1'b1};
				end else begin
					nrem[l] = rem_s[k][l];
					nquo[l] = {quo_s[k][l][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				rem_s[k+1][0] <= nrem[0];
				rem_s[k+1][1] <= nrem[1];
				quo_s[k+1][0] <= nquo[0];
				quo_s[k+1][1] <= nquo[1];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_side  = side_s[Q_W];
	assign out_q[0]  = quo_s[Q_W][0];
	assign out_q[1]  = quo_s[Q_W][1];

endmodule

`default_nettype wire

// ----- hdl/pinhole_point_projection_core.sv -----
// ----------------------------------------------------------------------------
// pinhole_point_projection_core
// Projects world points to pixels through R*P + t and a pinhole model.
//
// Channels: point (sink) takes one world point per beat, pixel (source)
// gives one pixel beat per point in the same order, cfg (sink, always
// ready) writes rotation, translation, intrinsics and the integer mode
// by register index; writes are expected only while no point is in flight.
// A point passes three stages of transform, two stages of scaling and
// sign handling, 25 divider stages (one quotient bit each), one offset
// and clamp stage and the output register. Throughput is one point per
// cycle unless stalled, set by the fully pipelined divider. Reset clears
// all valid bits and loads identity rotation, zero translation, unit
// focal lengths, zero principal point and fractional output. When the
// receiver stalls, one more beat is caught in a skid register, then the
// whole pipeline holds and point.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_point_projection_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ppp_point_if.sink   point,
	ppp_pixel_if.source pixel,
	ppp_cfg_if.sink     cfg
);
	import ppp_pkg::*;

	logic [47:0] rot0_q, rot1_q, rot2_q, focal_q, princ_q;
	logic [62:0] trans_q;
	logic        integ_q;

	logic                      en;
	logic                      cam_valid_s3;
	logic signed [COORD_W-1:0] cam_s3 [3];
	logic                      cam_sat_s3;

	logic                      valid_s4;
	logic signed [NUM_W-1:0]   num_s4 [2];
	logic signed [COORD_W-1:0] cz_s4;
	logic                      sat_s4;

	logic                      valid_s5;
	side_t                     side_s5;
	logic [MAG_W-1:0]          mag_s5 [2];
	logic [DEN_W-1:0]          den_s5;

	logic                      div_valid;
	side_t                     div_side;
	logic [Q_W-1:0]            div_q [2];

	logic                      valid_s6;
	pix_t                      pix_s6;
	pix_t                      pix_n;
	logic signed [COORD_W-1:0] axis_n [2];
	logic                      axsat_n [2];

	logic                      out_v_q;
	pix_t                      out_q;
	logic                      skid_v_q;
	pix_t                      skid_q;

	assign en = !skid_v_q;
	assign point.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot0_q  <= ROT0_RST;
			rot1_q  <= ROT1_RST;
			rot2_q  <= ROT2_RST;
			trans_q <= TRANS_RST;
			focal_q <= FOCAL_RST;
			princ_q <= PRINC_RST;
			integ_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROT0:  rot0_q  <= cfg.data[47:0];
				REG_ROT1:  rot1_q  <= cfg.data[47:0];
				REG_ROT2:  rot2_q  <= cfg.data[47:0];
				REG_TRANS: trans_q <= cfg.data;
				REG_FOCAL: focal_q <= cfg.data[47:0];
				REG_PRINC: princ_q <= cfg.data[47:0];
				REG_INTEG: integ_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	ppp_cam u_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (point.valid),
		.px       (point.point_x),
		.py       (point.point_y),
		.pz       (point.point_z),
		.rot0     (rot0_q),
		.rot1     (rot1_q),
		.rot2     (rot2_q),
		.trans    (trans_q),
		.valid_s3 (cam_valid_s3),
		.cam_s3   (cam_s3),
		.sat_s3   (cam_sat_s3)
	);

	// focal scaling, then magnitudes and range check for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= cam_valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4[0] <= $signed({1'b0, focal_q[23:0]}) * cam_s3[0];
			num_s4[1] <= $signed({1'b0, focal_q[47:24]}) * cam_s3[1];
			cz_s4     <= cam_s3[2];
			sat_s4    <= cam_sat_s3;

			den_s5 <= cz_s4[COORD_W-1] ? DEN_W'(-cz_s4) : DEN_W'(cz_s4);
			side_s5.zd  <= (cz_s4 == '0);
			side_s5.sat <= sat_s4;
			for (int a = 0; a < 2; a++) begin
				mag_s5[a] <= num_s4[a][NUM_W-1] ? MAG_W'(-num_s4[a]) : MAG_W'(num_s4[a]);
				side_s5.neg[a] <= num_s4[a][NUM_W-1] ^ cz_s4[COORD_W-1];
				side_s5.ovf[a] <= (MAG_W'(MAG_W'(num_s4[a][NUM_W-1] ? -num_s4[a]
					: num_s4[a]) >> Q_W)) >= MAG_W'(cz_s4[COORD_W-1] ? -cz_s4 : cz_s4);
			end
		end
	end

	ppp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_side   (side_s5),
		.in_num    (mag_s5),
		.in_den    (den_s5),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_q     (div_q)
	);

	// sign, principal offset, clamp and whole-pixel truncation
	always_comb begin
		logic signed [Q_W+1:0] qs;
		logic signed [Q_W+1:0] sum;
		logic signed [COORD_W-1:0] v;
		logic [COORD_W:0] m;
		for (int a = 0; a < 2; a++) begin
			qs = div_side.neg[a] ? -$signed({2'b00, div_q[a]}) : $signed({2'b00, div_q[a]});
			sum = qs + $signed({3'b000, princ_q[24*a +: 24]});
			axsat_n[a] = 1'b1;
			m = '0;
			if (div_side.ovf[a]) begin
				v = div_side.neg[a] ? Q_MIN : Q_MAX;
			end else if (sum > (Q_W+2)'(Q_MAX)) begin
				v = Q_MAX;
			end else if (sum < (Q_W+2)'(Q_MIN)) begin
				v = Q_MIN;
			end else begin
				v = COORD_W'(sum);
				axsat_n[a] = 1'b0;
			end
			if (integ_q) begin
				if (v[COORD_W-1]) begin
					m = (COORD_W+1)'(-$signed({v[COORD_W-1], v}));
					m[7:0] = 8'h00;
					v = COORD_W'(-$signed(m));
				end else begin
					v[7:0] = 8'h00;
				end
			end
			axis_n[a] = v;
		end
		pix_n.zd  = div_side.zd;
		pix_n.x   = div_side.zd ? '0 : axis_n[0];
		pix_n.y   = div_side.zd ? '0 : axis_n[1];
		pix_n.sat = div_side.sat | (!div_side.zd & (axsat_n[0] | axsat_n[1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s6 <= pix_n;
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (valid_s6) begin
				if (!out_v_q || pixel.ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pixel.ready) begin
				out_v_q <= 1'b0;
			end
		end else if (pixel.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_s6) begin
				if (!out_v_q || pixel.ready) begin
					out_q <= pix_s6;
				end else begin
					skid_q <= pix_s6;
				end
			end
		end else if (pixel.ready) begin
			out_q <= skid_q;
		end
	end

	assign pixel.valid      = out_v_q;
	assign pixel.pixel_x    = out_q.x;
	assign pixel.pixel_y    = out_q.y;
	assign pixel.zero_depth = out_q.zd;
	assign pixel.saturated  = out_q.sat;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a pending output beat");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !pixel.ready))
		else $error("skid entry filled without an output stall");

	a_zero_depth_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.zd) |-> (out_q.x == '0 && out_q.y == '0))
		else $error("zero depth beat with nonzero pixel");

endmodule

`default_nettype wire
